FILE: rtl/core/cfc_pkg.sv
// ----------------------------------------------------------------------------
// cfc_pkg: shared types and constants of the character class counter
// Item layouts, command and group codes, counter width and the control
// structs passed between the counter, store and result sequencer.
// ----------------------------------------------------------------------------
package cfc_pkg;

    localparam int NUM_CLASSES = 6;
    localparam int CNT_W       = 11;
    localparam int EPOCH_BITS  = 8;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_CHAR = 2'd1;
    localparam logic [1:0] CMD_EOL  = 2'd2;

    localparam logic [2:0] GRP_LINE = 3'd0;
    localparam logic [2:0] GRP_LAST = 3'd6;

    typedef logic [CNT_W-1:0] t_cnt;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] code_point;
        logic [5:0]  class_bits;
    } t_in_item;

    typedef struct packed {
        logic [2:0] group;
        t_cnt       count;
        t_cnt       distinct;
        logic       last;
    } t_out_item;

    // Counter values of one finished line.
    typedef struct packed {
        t_cnt                   len;
        t_cnt                   ldist;
        t_cnt [NUM_CLASSES-1:0] ccnt;
        t_cnt [NUM_CLASSES-1:0] cdist;
    } t_snap;

    // Write-back request for the entry read by the item in the update stage.
    typedef struct packed {
        logic tbl_we;
        logic seen_we;
        logic line_end;
    } t_store_cmd;

    typedef struct packed {
        logic busy;
        logic epoch_last;
    } t_store_stat;

    function automatic t_cnt sat_inc(input t_cnt v);
        return (v == CNT_MAX) ? v : v + t_cnt'(1);
    endfunction

endpackage

FILE: rtl/core/cfc_store.sv
// ----------------------------------------------------------------------------
// cfc_store: class table and seen-mark memories
// Synchronous-read memories with write-back forwarding, per-line
// epoch marks for the seen store and the sweep that clears the memories.
// ----------------------------------------------------------------------------
module cfc_store #(
    parameter int CODE_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  logic [CODE_BITS-1:0] i_rd_addr,
    input  cfc_pkg::t_store_cmd  i_cmd,
    input  logic [5:0]           i_tbl_data,
    output logic [5:0]           o_rd_class,
    output logic                 o_rd_seen,
    output cfc_pkg::t_store_stat o_stat
);

    localparam int DEPTH = 1 << CODE_BITS;

    logic [5:0]                     r_tbl_mem [DEPTH];
    logic [cfc_pkg::EPOCH_BITS-1:0] r_seen_mem [DEPTH];

    logic [5:0]                     r_tbl_q;
    logic [cfc_pkg::EPOCH_BITS-1:0] r_seen_q;
    logic [CODE_BITS-1:0]           r_s1_addr;

    logic [CODE_BITS-1:0]           r_fwd_addr;
    logic                           r_fwd_tbl_v;
    logic                           r_fwd_seen_v;
    logic [5:0]                     r_fwd_tbl;
    logic [cfc_pkg::EPOCH_BITS-1:0] r_fwd_seen;

    logic                           r_clearing;
    logic                           r_clr_tbl;
    logic [CODE_BITS-1:0]           r_clr_addr;
    logic [cfc_pkg::EPOCH_BITS-1:0] r_epoch;

    logic                           w_tbl_we;
    logic                           w_seen_we;
    logic [CODE_BITS-1:0]           w_wr_addr;
    logic [5:0]                     w_tbl_wdata;
    logic [cfc_pkg::EPOCH_BITS-1:0] w_seen_wdata;
    logic                           w_fwd_hit;
    logic [cfc_pkg::EPOCH_BITS-1:0] w_seen_word;

    // Outside a sweep, writes target the entry read for the item now in the update stage.
    assign w_wr_addr    = r_clearing ? r_clr_addr : r_s1_addr;
    assign w_tbl_we     = (r_clearing & r_clr_tbl) | i_cmd.tbl_we;
    assign w_seen_we    = r_clearing | i_cmd.seen_we;
    assign w_tbl_wdata  = r_clearing ? 6'd0 : i_tbl_data;
    assign w_seen_wdata = r_clearing ? '0 : r_epoch;

    always_ff @(posedge i_clk) begin
        if (w_tbl_we) begin
            r_tbl_mem[w_wr_addr] <= w_tbl_wdata;
        end
        if (w_seen_we) begin
            r_seen_mem[w_wr_addr] <= w_seen_wdata;
        end
        if (i_rd_en) begin
            r_tbl_q   <= r_tbl_mem[i_rd_addr];
            r_seen_q  <= r_seen_mem[i_rd_addr];
            r_s1_addr <= i_rd_addr;
        end
    end

    // The read at an edge misses the write made at the same edge, so that
    // write is registered and substituted on an address match.
    always_ff @(posedge i_clk) begin
        r_fwd_addr <= r_s1_addr;
        r_fwd_tbl  <= i_tbl_data;
        r_fwd_seen <= r_epoch;
        if (!i_rst_n) begin
            r_fwd_tbl_v  <= 1'b0;
            r_fwd_seen_v <= 1'b0;
        end else begin
            r_fwd_tbl_v  <= i_cmd.tbl_we;
            r_fwd_seen_v <= i_cmd.seen_we;
        end
    end

    assign w_fwd_hit   = (r_fwd_addr == r_s1_addr);
    assign o_rd_class  = (w_fwd_hit && r_fwd_tbl_v) ? r_fwd_tbl : r_tbl_q;
    assign w_seen_word = (w_fwd_hit && r_fwd_seen_v) ? r_fwd_seen : r_seen_q;
    assign o_rd_seen   = (w_seen_word == r_epoch);

    // Epoch zero marks a cleared entry; when the epochs run out the seen
    // store is swept back to zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_tbl  <= 1'b1;
            r_clr_addr <= '0;
            r_epoch    <= cfc_pkg::EPOCH_BITS'(1);
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + CODE_BITS'(1);
            if (r_clr_addr == '1) begin
                r_clearing <= 1'b0;
            end
        end else if (i_cmd.line_end) begin
            if (r_epoch == '1) begin
                r_epoch    <= cfc_pkg::EPOCH_BITS'(1);
                r_clearing <= 1'b1;
                r_clr_tbl  <= 1'b0;
                r_clr_addr <= '0;
            end else begin
                r_epoch <= r_epoch + cfc_pkg::EPOCH_BITS'(1);
            end
        end
    end

    assign o_stat.busy       = r_clearing;
    assign o_stat.epoch_last = (r_epoch == '1);

endmodule

FILE: rtl/core/cfc_count.sv
// ----------------------------------------------------------------------------
// cfc_count: update stage and line counters
// Takes the memory read data of the item in flight, forms the write-back,
// updates the saturating counters and hands finished lines to the output.
// ----------------------------------------------------------------------------
module cfc_count #(
    parameter int MAX_LINE = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  cfc_pkg::t_in_item   i_item,
    input  logic [5:0]          i_rd_class,
    input  logic                i_rd_seen,
    input  logic                i_epoch_last,
    input  logic                i_snap_free,
    output cfc_pkg::t_store_cmd o_cmd,
    output logic [5:0]          o_tbl_data,
    output logic                o_snap_load,
    output cfc_pkg::t_snap      o_snap,
    output logic                o_stall
);

    logic              r_s1_valid;
    cfc_pkg::t_in_item r_s1_item;
    cfc_pkg::t_snap    r_cnt;
    cfc_pkg::t_snap    n_cnt;

    logic w_eol;
    logic w_hold;
    logic w_full;
    logic w_first;

    assign w_eol   = r_s1_valid && (r_s1_item.command == cfc_pkg::CMD_EOL);
    assign w_hold  = w_eol && !i_snap_free;
    assign o_stall = w_hold || (w_eol && i_epoch_last);
    assign w_full  = 32'(r_cnt.len) >= 32'(MAX_LINE);
    assign w_first = !i_rd_seen;

    assign o_tbl_data = i_rd_class | r_s1_item.class_bits;
    assign o_snap     = r_cnt;

    always_comb begin
        n_cnt          = r_cnt;
        o_cmd.tbl_we   = 1'b0;
        o_cmd.seen_we  = 1'b0;
        o_cmd.line_end = 1'b0;
        o_snap_load    = 1'b0;
        if (r_s1_valid) begin
            case (r_s1_item.command)
                cfc_pkg::CMD_LOAD: begin
                    o_cmd.tbl_we = 1'b1;
                end
                cfc_pkg::CMD_CHAR: begin
                    if (!w_full) begin
                        o_cmd.seen_we = 1'b1;
                        n_cnt.len     = cfc_pkg::sat_inc(r_cnt.len);
                        if (w_first) begin
                            n_cnt.ldist = cfc_pkg::sat_inc(r_cnt.ldist);
                        end
                        for (int k = 0; k < cfc_pkg::NUM_CLASSES; k++) begin
                            if (i_rd_class[k]) begin
                                n_cnt.ccnt[k] = cfc_pkg::sat_inc(r_cnt.ccnt[k]);
                                if (w_first) begin
                                    n_cnt.cdist[k] = cfc_pkg::sat_inc(r_cnt.cdist[k]);
                                end
                            end
                        end
                    end
                end
                cfc_pkg::CMD_EOL: begin
                    if (!w_hold) begin
                        o_snap_load    = 1'b1;
                        o_cmd.line_end = 1'b1;
                        n_cnt          = '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_item <= i_item;
        end
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_cnt      <= '0;
        end else begin
            r_s1_valid <= i_accept || w_hold;
            r_cnt      <= n_cnt;
        end
    end

endmodule

FILE: rtl/core/cfc_emit.sv
// ----------------------------------------------------------------------------
// cfc_emit: result sequencer
// Holds the counters of one finished line and sends them as seven result
// items, whole line first and the symbol class last.
// ----------------------------------------------------------------------------
module cfc_emit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_snap_load,
    input  cfc_pkg::t_snap     i_snap,
    output logic               o_snap_free,
    output logic               o_valid,
    input  logic               i_ready,
    output cfc_pkg::t_out_item o_item
);

    cfc_pkg::t_snap r_snap;
    logic           r_busy;
    logic [2:0]     r_grp;
    logic [2:0]     w_cls;

    assign o_snap_free = !r_busy;
    assign o_valid     = r_busy;
    assign w_cls       = r_grp - 3'd1;

    always_comb begin
        o_item.group = r_grp;
        o_item.last  = (r_grp == cfc_pkg::GRP_LAST);
        if (r_grp == cfc_pkg::GRP_LINE) begin
            o_item.count    = r_snap.len;
            o_item.distinct = r_snap.ldist;
        end else begin
            o_item.count    = r_snap.ccnt[w_cls];
            o_item.distinct = r_snap.cdist[w_cls];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_snap_load) begin
            r_snap <= i_snap;
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_grp  <= cfc_pkg::GRP_LINE;
        end else if (i_snap_load) begin
            r_busy <= 1'b1;
            r_grp  <= cfc_pkg::GRP_LINE;
        end else if (r_busy && i_ready) begin
            r_grp <= r_grp + 3'd1;
            if (r_grp == cfc_pkg::GRP_LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

endmodule

FILE: rtl/core/char_class_feature_counter_core.sv
// ----------------------------------------------------------------------------
// char_class_feature_counter_core: per-line character class statistics
// Class table loads, character counting with distinct tracking, and a burst
// of seven result items at each end of line.
// ----------------------------------------------------------------------------
// Load and character items are taken one per cycle while no sweep or stall
// holds the input: an item reads the class table and the seen store when it
// is accepted and writes back in the next cycle, with the last write forwarded
// so that back-to-back items on the same code point see each other. An
// end-of-line item hands the counters to the result sequencer, which sends
// seven items at one per cycle while the receiver is ready and character input
// continues; a second end of line arriving before that burst is done waits for
// it. After reset the block takes no item while both memories are swept clear.
// The seen store tags each entry with a line number; every 255 lines the
// numbers run out and the seen store is swept again: the block takes no item
// during that sweep, nor in the cycle of that end of line.
module char_class_feature_counter_core #(
    parameter int CODE_BITS = 16,
    parameter int MAX_LINE  = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  cfc_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output cfc_pkg::t_out_item o_item
);

    logic                 w_accept;
    logic                 w_stall;
    logic [5:0]           w_rd_class;
    logic                 w_rd_seen;
    logic [5:0]           w_tbl_data;
    logic                 w_snap_load;
    logic                 w_snap_free;
    cfc_pkg::t_snap       w_snap;
    cfc_pkg::t_store_cmd  w_cmd;
    cfc_pkg::t_store_stat w_stat;

    assign o_ready  = !w_stat.busy && !w_stall;
    assign w_accept = i_valid && o_ready;

    cfc_store #(
        .CODE_BITS(CODE_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_accept),
        .i_rd_addr (CODE_BITS'(i_item.code_point)),
        .i_cmd     (w_cmd),
        .i_tbl_data(w_tbl_data),
        .o_rd_class(w_rd_class),
        .o_rd_seen (w_rd_seen),
        .o_stat    (w_stat)
    );

    cfc_count #(
        .MAX_LINE(MAX_LINE)
    ) u_count (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_item      (i_item),
        .i_rd_class  (w_rd_class),
        .i_rd_seen   (w_rd_seen),
        .i_epoch_last(w_stat.epoch_last),
        .i_snap_free (w_snap_free),
        .o_cmd       (w_cmd),
        .o_tbl_data  (w_tbl_data),
        .o_snap_load (w_snap_load),
        .o_snap      (w_snap),
        .o_stall     (w_stall)
    );

    cfc_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_snap_load(w_snap_load),
        .i_snap     (w_snap),
        .o_snap_free(w_snap_free),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_item     (o_item)
    );

    // No item may be taken while a memory sweep owns the write port.
    a_no_accept_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.busy |-> !w_accept)
        else $error("item accepted during memory sweep");

    // A finished line is only handed over when the sequencer is empty.
    a_snap_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_snap_load |-> w_snap_free)
        else $error("line counters overwrote a pending burst");

    // After a handover the burst starts with the whole-line result.
    a_burst_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_snap_load |=> (o_valid && o_item.group == cfc_pkg::GRP_LINE))
        else $error("result burst did not start with the whole line");

    // The last flag marks exactly the symbol-class result.
    a_last_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_item.last == (o_item.group == cfc_pkg::GRP_LAST)))
        else $error("last flag on the wrong result");

endmodule

FILE: test/tb_char_class_feature_counter_core.sv
// ----------------------------------------------------------------------------
// tb_char_class_feature_counter_core: line statistics of the class counter
// Drives load, character, end-of-line and unused-command items into the core
// and predicts the class table, seen marks and line counters itself. Every
// result item is checked field by field against the oldest prediction, under
// phases of sender idling, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_char_class_feature_counter_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          LINE_LIMIT = 1024;
    localparam int          TABLE_SIZE = 65536;
    localparam logic [1:0]  CMD_NONE   = 2'd3;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    cfc_pkg::t_in_item  i_item  = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    cfc_pkg::t_out_item o_item;

    // Predicted state of the block.
    logic [5:0]    class_tbl [TABLE_SIZE];
    bit            seen_cp [int];
    cfc_pkg::t_cnt line_len;
    cfc_pkg::t_cnt line_dist;
    cfc_pkg::t_cnt cls_cnt  [cfc_pkg::NUM_CLASSES];
    cfc_pkg::t_cnt cls_dist [cfc_pkg::NUM_CLASSES];

    cfc_pkg::t_out_item line_stats_q [$];
    int                 errors     = 0;
    int                 idle_pct   = 0;
    int                 stall_pct  = 0;
    int                 hold_left  = 0;

    char_class_feature_counter_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    always #2 i_clk = ~i_clk;

    function automatic cfc_pkg::t_cnt bump(input cfc_pkg::t_cnt v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic void clear_line_stats();
        seen_cp.delete();
        line_len  = '0;
        line_dist = '0;
        for (int k = 0; k < cfc_pkg::NUM_CLASSES; k++) begin
            cls_cnt[k]  = '0;
            cls_dist[k] = '0;
        end
    endfunction

    function automatic cfc_pkg::t_in_item mk_item(input logic [1:0] cmd,
                                                  input logic [15:0] cp,
                                                  input logic [5:0] bits);
        cfc_pkg::t_in_item it;
        it.command    = cmd;
        it.code_point = cp;
        it.class_bits = bits;
        return it;
    endfunction

    // Updates the predicted state for one accepted item and queues the
    // seven line results at an end of line.
    function automatic void count_line_item(input cfc_pkg::t_in_item it);
        logic [5:0]         cls;
        bit                 first;
        cfc_pkg::t_out_item r;
        case (it.command)
            cfc_pkg::CMD_LOAD: begin
                class_tbl[it.code_point] = class_tbl[it.code_point] | it.class_bits;
            end
            cfc_pkg::CMD_CHAR: begin
                if (line_len < LINE_LIMIT) begin
                    cls   = class_tbl[it.code_point];
                    first = !seen_cp.exists(int'(it.code_point));
                    seen_cp[int'(it.code_point)] = 1'b1;
                    line_len = bump(line_len);
                    if (first)
                        line_dist = bump(line_dist);
                    for (int k = 0; k < cfc_pkg::NUM_CLASSES; k++) begin
                        if (cls[k]) begin
                            cls_cnt[k] = bump(cls_cnt[k]);
                            if (first)
                                cls_dist[k] = bump(cls_dist[k]);
                        end
                    end
                end
            end
            cfc_pkg::CMD_EOL: begin
                r.group    = cfc_pkg::GRP_LINE;
                r.count    = line_len;
                r.distinct = line_dist;
                r.last     = 1'b0;
                line_stats_q.push_back(r);
                for (int k = 0; k < cfc_pkg::NUM_CLASSES; k++) begin
                    r.group    = 3'(k + 1);
                    r.count    = cls_cnt[k];
                    r.distinct = cls_dist[k];
                    r.last     = (3'(k + 1) == cfc_pkg::GRP_LAST);
                    line_stats_q.push_back(r);
                end
                clear_line_stats();
            end
            default: begin
            end
        endcase
    endfunction

    // Called at a rising edge; returns at the edge where the item is taken.
    task automatic send_item(input cfc_pkg::t_in_item it);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        count_line_item(it);
    endtask

    task automatic wait_results_done();
        i_valid <= 1'b0;
        while (line_stats_q.size() != 0)
            @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_ready <= 1'b0;
            hold_left--;
        end else begin
            i_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cfc_pkg::t_out_item want;
        if (i_rst_n && o_valid && i_ready) begin
            if (line_stats_q.size() == 0) begin
                $display("%0t: unexpected result item %p", $time, o_item);
                errors++;
            end else begin
                want = line_stats_q.pop_front();
                if (o_item.group !== want.group) begin
                    $display("%0t: group expected %0d actual %0d",
                             $time, want.group, o_item.group);
                    errors++;
                end
                if (o_item.count !== want.count) begin
                    $display("%0t: group %0d count expected %0d actual %0d",
                             $time, want.group, want.count, o_item.count);
                    errors++;
                end
                if (o_item.distinct !== want.distinct) begin
                    $display("%0t: group %0d distinct expected %0d actual %0d",
                             $time, want.group, want.distinct, o_item.distinct);
                    errors++;
                end
                if (o_item.last !== want.last) begin
                    $display("%0t: group %0d last expected %0b actual %0b",
                             $time, want.group, want.last, o_item.last);
                    errors++;
                end
            end
        end
    end

    // Empty line, extreme code points and class bits, repeats and the
    // unused command.
    task automatic test_extremes();
        idle_pct  = 0;
        stall_pct = 0;
        send_item(mk_item(cfc_pkg::CMD_EOL, 16'h0000, 6'h00));
        send_item(mk_item(cfc_pkg::CMD_LOAD, 16'h0000, 6'h3F));
        send_item(mk_item(cfc_pkg::CMD_LOAD, 16'hFFFF, 6'h01));
        send_item(mk_item(cfc_pkg::CMD_LOAD, 16'hFFFF, 6'h20));
        send_item(mk_item(cfc_pkg::CMD_LOAD, 16'h1234, 6'h00));
        send_item(mk_item(cfc_pkg::CMD_CHAR, 16'h0000, 6'h3F));
        send_item(mk_item(cfc_pkg::CMD_CHAR, 16'hFFFF, 6'h00));
        send_item(mk_item(cfc_pkg::CMD_CHAR, 16'h0000, 6'h15));
        send_item(mk_item(cfc_pkg::CMD_CHAR, 16'h8000, 6'h2A));
        send_item(mk_item(cfc_pkg::CMD_CHAR, 16'h1234, 6'h00));
        send_item(mk_item(CMD_NONE, 16'hFFFF, 6'h3F));
        send_item(mk_item(cfc_pkg::CMD_EOL, 16'hFFFF, 6'h3F));
        wait_results_done();
    endtask

    // Class bits loaded while the character is already counted in the line.
    task automatic test_load_mid_line();
        send_item(mk_item(cfc_pkg::CMD_LOAD, 16'h0041, 6'h01));
        send_item(mk_item(cfc_pkg::CMD_CHAR, 16'h0041, 6'h00));
        send_item(mk_item(cfc_pkg::CMD_LOAD, 16'h0041, 6'h0C));
        send_item(mk_item(cfc_pkg::CMD_CHAR, 16'h0041, 6'h00));
        send_item(mk_item(cfc_pkg::CMD_LOAD, 16'h0042, 6'h10));
        send_item(mk_item(cfc_pkg::CMD_CHAR, 16'h0042, 6'h00));
        send_item(mk_item(cfc_pkg::CMD_CHAR, 16'h0042, 6'h00));
        send_item(mk_item(cfc_pkg::CMD_EOL, 16'h0000, 6'h00));
        wait_results_done();
    endtask

    // More characters than a line may hold; the extra ones, including a
    // code point not seen before, must leave no trace.
    task automatic test_long_line();
        for (int k = 0; k < 8; k++)
            send_item(mk_item(cfc_pkg::CMD_LOAD, 16'(100 + k), 6'(k * 9 + 1)));
        send_item(mk_item(cfc_pkg::CMD_LOAD, 16'd500, 6'h3F));
        for (int n = 0; n < LINE_LIMIT + 6; n++) begin
            if (n == LINE_LIMIT + 2)
                send_item(mk_item(cfc_pkg::CMD_CHAR, 16'd500, 6'h00));
            else
                send_item(mk_item(cfc_pkg::CMD_CHAR, 16'(100 + n % 8), 6'h00));
        end
        send_item(mk_item(cfc_pkg::CMD_EOL, 16'h0000, 6'h00));
        send_item(mk_item(cfc_pkg::CMD_CHAR, 16'd500, 6'h00));
        send_item(mk_item(cfc_pkg::CMD_EOL, 16'h0000, 6'h00));
        wait_results_done();
    endtask

    // Lines of random length over a small pool of code points, with loads
    // mixed in, some unused commands and some lines left without an end.
    task automatic test_random_traffic(input int idle, input int stall, input int n_items);
        logic [15:0] pool [8];
        int          sent;
        int          len;
        int          r;
        idle_pct  = idle;
        stall_pct = stall;
        sent      = 0;
        foreach (pool[k])
            pool[k] = 16'($urandom);
        pool[0] = 16'h0000;
        pool[1] = 16'hFFFF;
        while (sent < n_items) begin
            pool[$urandom_range(7)] = 16'($urandom);
            len = $urandom_range(12);
            for (int n = 0; n < len; n++) begin
                r = $urandom_range(99);
                if (r < 20) begin
                    send_item(mk_item(cfc_pkg::CMD_LOAD, pool[$urandom_range(7)],
                                      6'($urandom_range(63))));
                    sent++;
                end else if (r < 25) begin
                    send_item(mk_item(CMD_NONE, 16'($urandom), 6'($urandom)));
                end else begin
                    send_item(mk_item(cfc_pkg::CMD_CHAR, pool[$urandom_range(7)],
                                      6'($urandom)));
                    sent++;
                end
            end
            if ($urandom_range(9) != 0) begin
                send_item(mk_item(cfc_pkg::CMD_EOL, 16'($urandom), 6'($urandom)));
                sent++;
            end
        end
        send_item(mk_item(cfc_pkg::CMD_EOL, 16'($urandom), 6'($urandom)));
        wait_results_done();
    endtask

    // The receiver holds off long enough for the result path to fill, so
    // that a second end of line and the characters behind it must wait.
    task automatic test_output_pressure();
        idle_pct  = 0;
        stall_pct = 0;
        hold_left = 400;
        for (int l = 0; l < 3; l++) begin
            for (int n = 0; n < 5; n++)
                send_item(mk_item(cfc_pkg::CMD_CHAR, 16'(l * 3 + n % 3), 6'h00));
            send_item(mk_item(cfc_pkg::CMD_EOL, 16'h0000, 6'h00));
        end
        for (int n = 0; n < 30; n++)
            send_item(mk_item(cfc_pkg::CMD_CHAR, 16'(n % 4), 6'h00));
        send_item(mk_item(cfc_pkg::CMD_EOL, 16'h0000, 6'h00));
        wait_results_done();
    endtask

    initial begin
        foreach (class_tbl[k])
            class_tbl[k] = '0;
        clear_line_stats();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_load_mid_line();
        test_long_line();
        test_random_traffic(0, 0, 58);
        test_random_traffic(68, 0, 58);
        test_random_traffic(0, 68, 58);
        test_random_traffic(38, 38, 58);
        test_output_pressure();
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Time limit for the whole run, the clearing sweep after reset included.
    initial begin
        #20000000;
        $display("simulation failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/cfc_pkg.sv
rtl/core/cfc_store.sv
rtl/core/cfc_count.sv
rtl/core/cfc_emit.sv
rtl/core/char_class_feature_counter_core.sv
test/tb_char_class_feature_counter_core.sv
